// ===== design/lru_page_frame_tracker_macros.svh =====
// ----------------------------------------------------------------------------
// lru page frame tracker assertion macros
// shared property forms for the tracker checks
// ----------------------------------------------------------------------------
`ifndef LRU_PAGE_FRAME_TRACKER_MACROS_SVH
`define LRU_PAGE_FRAME_TRACKER_MACROS_SVH

// same-cycle implication
`define LPFT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lpft same-cycle check failed");

// next-cycle implication
`define LPFT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lpft next-cycle check failed");

`endif

// ===== design/lpft_pkg.sv =====
// ----------------------------------------------------------------------------
// lpft_pkg
// widths, defaults and beat records shared by the page frame tracker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpft_pkg;

   localparam int ADDR_W        = 12;
   localparam int PAGE_W        = 9;
   localparam int CNT_W         = 16;
   localparam int FRAME_OUT_W   = 2;
   localparam int FRAMES_MAX    = 16;
   localparam int IDX_W         = $clog2(FRAMES_MAX);
   localparam int AGE_W         = $clog2(FRAMES_MAX);
   localparam int FRAMES_DEF    = 4;
   localparam int PAGE_SIZE_DEF = 10;

   // running search record handed from cell to cell
   typedef struct packed {
      logic              hit_found;
      logic [IDX_W-1:0]  hit_idx;
      logic [AGE_W-1:0]  hit_age;
      logic              empty_found;
      logic [IDX_W-1:0]  empty_idx;
      logic [AGE_W-1:0]  old_age;
      logic [IDX_W-1:0]  old_idx;
      logic [PAGE_W-1:0] old_page;
   } search_type;

   // update broadcast to every cell
   typedef struct packed {
      logic              en;
      logic              is_hit;
      logic [IDX_W-1:0]  slot;
      logic [AGE_W-1:0]  hit_age;
      logic [PAGE_W-1:0] page;
   } update_type;

endpackage

// ===== design/lru_page_frame_tracker.sv =====
// ----------------------------------------------------------------------------
// lru_page_frame_tracker
// fully associative page frames with true lru replacement
// ----------------------------------------------------------------------------
// usage:
//   request channel: raise start with req_address; the beat is taken at a
//   clock edge where start is high and busy is low. busy stays high while
//   the beat is worked on.
//   response channel: rsp_valid strobes for one cycle with hit, frame,
//   replaced, evicted_page and the saturating hit and fault counts. there
//   is no back pressure; the receiver must take the beat in that cycle.
//   order: the page number multiply is registered first, then the search
//   record walks the row of frame cells, one cell a cycle, and the
//   response is registered from the end of the row. busy is already low
//   in the response cycle, so a new beat is taken only once the last one
//   has been answered.
//   reset: synchronous; all frames empty, counts zero, no response pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_page_frame_tracker #(
   parameter int FRAMES    = lpft_pkg::FRAMES_DEF,
   parameter int PAGE_SIZE = lpft_pkg::PAGE_SIZE_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [lpft_pkg::ADDR_W-1:0]      req_address,
   output logic                             rsp_valid,
   output logic                             rsp_hit,
   output logic [lpft_pkg::FRAME_OUT_W-1:0] rsp_frame,
   output logic                             rsp_replaced,
   output logic [lpft_pkg::PAGE_W-1:0]      rsp_evicted_page,
   output logic [lpft_pkg::CNT_W-1:0]       rsp_hit_count,
   output logic [lpft_pkg::CNT_W-1:0]       rsp_fault_count
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_LAUNCH = 2'd1;
   localparam logic [1:0] ST_WALK   = 2'd2;
   localparam logic [lpft_pkg::CNT_W-1:0] CNT_MAX = '1;

   logic [1:0]                        state_ff;
   logic [1:0]                        state_in;
   logic                              accept;
   logic                              done;
   logic [lpft_pkg::PAGE_W-1:0]       page;
   logic                              tok_chain [0:FRAMES];
   lpft_pkg::search_type              rec_chain [0:FRAMES];
   lpft_pkg::search_type              fin;
   lpft_pkg::update_type              cmd_ff;
   lpft_pkg::update_type              cmd_in;
   logic                              dec_replaced;
   logic [lpft_pkg::PAGE_W-1:0]       dec_evicted;
   logic [lpft_pkg::CNT_W-1:0]        hits_ff;
   logic [lpft_pkg::CNT_W-1:0]        hits_in;
   logic [lpft_pkg::CNT_W-1:0]        faults_ff;
   logic [lpft_pkg::CNT_W-1:0]        faults_in;
   logic                              rsp_valid_ff;
   logic                              rsp_hit_ff;
   logic [lpft_pkg::FRAME_OUT_W-1:0]  rsp_frame_ff;
   logic                              rsp_replaced_ff;
   logic [lpft_pkg::PAGE_W-1:0]       rsp_evicted_ff;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign done   = (state_ff == ST_WALK) && tok_chain[FRAMES];

   lpft_page_div #(
      .PAGE_SIZE (PAGE_SIZE)
   ) u_div (
      .clock   (clock),
      .load    (accept),
      .address (req_address),
      .page    (page)
   );

   assign tok_chain[0] = (state_ff == ST_LAUNCH);
   assign rec_chain[0] = '0;

   for (genvar g = 0; g < FRAMES; g++) begin : g_cell
      lpft_cell #(
         .CELL_IDX (g)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .tok_in  (tok_chain[g]),
         .rec_in  (rec_chain[g]),
         .page_q  (page),
         .upd     (cmd_ff),
         .tok_out (tok_chain[g+1]),
         .rec_out (rec_chain[g+1])
      );
   end

   assign fin = rec_chain[FRAMES];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LAUNCH;
            end
         end
         ST_LAUNCH: begin
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (tok_chain[FRAMES]) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd_in         = '0;
      cmd_in.en      = done;
      cmd_in.page    = page;
      cmd_in.hit_age = fin.hit_age;
      dec_replaced   = 1'b0;
      dec_evicted    = '0;
      hits_in        = hits_ff;
      faults_in      = faults_ff;
      priority if (fin.hit_found) begin
         cmd_in.is_hit = 1'b1;
         cmd_in.slot   = fin.hit_idx;
         if (hits_ff != CNT_MAX) begin
            hits_in = hits_ff + 1'b1;
         end
      end else if (fin.empty_found) begin
         cmd_in.slot = fin.empty_idx;
         if (faults_ff != CNT_MAX) begin
            faults_in = faults_ff + 1'b1;
         end
      end else begin
         cmd_in.slot  = fin.old_idx;
         dec_replaced = 1'b1;
         dec_evicted  = fin.old_page;
         if (faults_ff != CNT_MAX) begin
            faults_in = faults_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmd_ff       <= '0;
         hits_ff      <= '0;
         faults_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmd_ff       <= cmd_in;
         rsp_valid_ff <= done;
         if (done) begin
            hits_ff   <= hits_in;
            faults_ff <= faults_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_hit_ff      <= cmd_in.is_hit;
         rsp_frame_ff    <= cmd_in.slot[lpft_pkg::FRAME_OUT_W-1:0];
         rsp_replaced_ff <= dec_replaced;
         rsp_evicted_ff  <= dec_evicted;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_frame        = rsp_frame_ff;
   assign rsp_replaced     = rsp_replaced_ff;
   assign rsp_evicted_page = rsp_evicted_ff;
   assign rsp_hit_count    = hits_ff;
   assign rsp_fault_count  = faults_ff;

`include "lru_page_frame_tracker_macros.svh"

   `LPFT_ASSERT_NXT(a_accept_busy, clock, reset, accept, busy)
   `LPFT_ASSERT_IMP(a_rsp_idle, clock, reset, rsp_valid, !busy)
   `LPFT_ASSERT_IMP(a_evict_miss, clock, reset, rsp_valid && rsp_replaced, !rsp_hit)
   `LPFT_ASSERT_IMP(a_evict_zero, clock, reset, rsp_valid && !rsp_replaced, rsp_evicted_page == '0)

endmodule

// ===== design/lpft_page_div.sv =====
// ----------------------------------------------------------------------------
// lpft_page_div
// page number from address by reciprocal multiply, result registered
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpft_page_div #(
   parameter int PAGE_SIZE = lpft_pkg::PAGE_SIZE_DEF
) (
   input  logic                        clock,
   input  logic                        load,
   input  logic [lpft_pkg::ADDR_W-1:0] address,
   output logic [lpft_pkg::PAGE_W-1:0] page
);

   localparam int LOG_D  = $clog2(PAGE_SIZE);
   localparam int SHIFT  = lpft_pkg::ADDR_W + LOG_D;
   localparam int PROD_W = 2 * lpft_pkg::ADDR_W + 1;
   localparam logic [PROD_W-1:0] RECIP =
      PROD_W'(((64'd1 << SHIFT) + 64'(PAGE_SIZE) - 64'd1) / 64'(PAGE_SIZE));

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;
   logic [PROD_W-1:0] quot;

   assign prod_in = PROD_W'(address) * RECIP;
   assign quot    = prod_ff >> SHIFT;
   assign page    = quot[lpft_pkg::PAGE_W-1:0];

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

endmodule

// ===== design/lpft_cell.sv =====
// ----------------------------------------------------------------------------
// lpft_cell
// one page frame: holds valid, page and age, merges into the search record
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpft_cell #(
   parameter int CELL_IDX = 0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        tok_in,
   input  lpft_pkg::search_type        rec_in,
   input  logic [lpft_pkg::PAGE_W-1:0] page_q,
   input  lpft_pkg::update_type        upd,
   output logic                        tok_out,
   output lpft_pkg::search_type        rec_out
);

   localparam logic [lpft_pkg::IDX_W-1:0] MY_IDX = lpft_pkg::IDX_W'(CELL_IDX);

   logic                        valid_ff;
   logic [lpft_pkg::PAGE_W-1:0] page_ff;
   logic [lpft_pkg::AGE_W-1:0]  age_ff;
   logic                        tok_ff;
   lpft_pkg::search_type        rec_ff;
   lpft_pkg::search_type        rec_in_nx;

   always_comb begin
      rec_in_nx = rec_in;
      if (valid_ff && (page_ff == page_q) && !rec_in.hit_found) begin
         rec_in_nx.hit_found = 1'b1;
         rec_in_nx.hit_idx   = MY_IDX;
         rec_in_nx.hit_age   = age_ff;
      end
      if (!valid_ff && !rec_in.empty_found) begin
         rec_in_nx.empty_found = 1'b1;
         rec_in_nx.empty_idx   = MY_IDX;
      end
      if (age_ff > rec_in.old_age) begin
         rec_in_nx.old_age  = age_ff;
         rec_in_nx.old_idx  = MY_IDX;
         rec_in_nx.old_page = page_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in_nx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         age_ff   <= '0;
      end else if (upd.en) begin
         if (upd.slot == MY_IDX) begin
            valid_ff <= 1'b1;
            age_ff   <= '0;
         end else if (valid_ff && (!upd.is_hit || (age_ff < upd.hit_age))) begin
            age_ff <= age_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (upd.en && !upd.is_hit && (upd.slot == MY_IDX)) begin
         page_ff <= upd.page;
      end
   end

   assign tok_out = tok_ff;
   assign rec_out = rec_ff;

endmodule
